### rtl/ppb_pkg.sv
// shared constants, types and word layouts of the perceptron branch predictor
`timescale 1ns / 1ps

package ppb_pkg;

    // perceptron geometry
    localparam int HIST_BITS     = 16;
    localparam int TABLE_ENTRIES = 256;   // power of two: the index is reduced by masking
    localparam int WEIGHT_BITS   = 8;

    localparam int ROW_LEN = HIST_BITS + 1;           // bias plus one weight per history bit
    localparam int ROW_W   = ROW_LEN * WEIGHT_BITS;   // one table row in bits
    localparam int IDX_W   = $clog2(TABLE_ENTRIES);
    localparam int W_MAX   = 2 ** (WEIGHT_BITS - 1) - 1;

    // adder tree: lanes are summed in groups, then the groups are summed
    localparam int GROUP   = 4;
    localparam int NGROUP  = (ROW_LEN + GROUP - 1) / GROUP;
    localparam int GSUM_W  = WEIGHT_BITS + $clog2(GROUP);
    localparam int SUM_W   = WEIGHT_BITS + $clog2(ROW_LEN);

    // word field widths
    localparam int IN_IDX_W   = 8;
    localparam int IN_HIST_W  = 16;
    localparam int THR_W      = 12;
    localparam int THR_RESET  = 45;
    localparam int DOT_W      = 13;
    localparam int DOT_MAX    = 2 ** (DOT_W - 1) - 1;
    localparam int IN_DATA_W  = 32;
    localparam int OUT_DATA_W = 16;
    localparam int USER_W     = 1;

    // compare widths for saturation and threshold checks
    localparam int CMP_W = (SUM_W > DOT_W ? SUM_W : DOT_W) + 1;
    localparam int MAG_W = (SUM_W > THR_W ? SUM_W : THR_W);

    // operation codes carried in tuser
    localparam logic [USER_W-1:0] OP_PREDICT = 1'b0;
    localparam logic [USER_W-1:0] OP_TRAIN   = 1'b1;

    typedef logic signed [WEIGHT_BITS-1:0] weight_t;
    typedef logic signed [SUM_W-1:0]       sum_t;
    typedef logic signed [GSUM_W-1:0]      gsum_t;

    // what one lane hands on: its signed term and its trained weight
    typedef struct packed {
        weight_t contrib;
        weight_t upd;
    } lane_out_t;

endpackage

### rtl/ppb_lane.sv
// one weight lane: signed term for the dot product and saturating training step
`timescale 1ns / 1ps

module ppb_lane
(
    input  ppb_pkg::weight_t   weight,
    input  logic               hbit,
    input  logic               taken,
    output ppb_pkg::lane_out_t lane_out
);

    localparam ppb_pkg::weight_t W_HI = ppb_pkg::WEIGHT_BITS'(ppb_pkg::W_MAX);
    localparam ppb_pkg::weight_t W_LO = ppb_pkg::WEIGHT_BITS'(-ppb_pkg::W_MAX);

    logic step_up;

    // move towards the outcome times the bit sign, holding at the limits
    assign step_up = (taken == hbit);

    always_comb
    begin
        // term is +w for a set history bit, -w for a clear one
        lane_out.contrib = hbit ? weight : -weight;
        if (step_up)
        begin
            lane_out.upd = (weight == W_HI) ? weight : weight + ppb_pkg::weight_t'(1);
        end
        else
        begin
            lane_out.upd = (weight == W_LO) ? weight : weight - ppb_pkg::weight_t'(1);
        end
    end

endmodule

### rtl/ppb_merge.sv
// merging adder tree: registered group sums, then the final sum of the groups
`timescale 1ns / 1ps

module ppb_merge
(
    input  logic             clk,
    input  logic             load,
    input  ppb_pkg::weight_t contrib [ppb_pkg::ROW_LEN],
    output ppb_pkg::sum_t    sum
);

    localparam int PAD = ppb_pkg::NGROUP * ppb_pkg::GROUP;

    ppb_pkg::weight_t contrib_pad [PAD];
    ppb_pkg::gsum_t   gsum_next   [ppb_pkg::NGROUP];
    ppb_pkg::gsum_t   gsum_reg    [ppb_pkg::NGROUP];

    // lanes padded with zero terms up to whole groups
    always_comb
    begin
        for (int i = 0; i < PAD; i++)
        begin
            contrib_pad[i] = '0;
        end
        for (int i = 0; i < ppb_pkg::ROW_LEN; i++)
        begin
            contrib_pad[i] = contrib[i];
        end
    end

    // first level: sum within each group
    always_comb
    begin
        for (int g = 0; g < ppb_pkg::NGROUP; g++)
        begin
            gsum_next[g] = '0;
            for (int l = 0; l < ppb_pkg::GROUP; l++)
            begin
                gsum_next[g] = gsum_next[g]
                             + ppb_pkg::GSUM_W'(contrib_pad[g * ppb_pkg::GROUP + l]);
            end
        end
    end

    // group sums held for the second level
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            gsum_reg <= gsum_next;
        end
    end

    // second level: sum of the groups
    always_comb
    begin
        sum = '0;
        for (int g = 0; g < ppb_pkg::NGROUP; g++)
        begin
            sum = sum + ppb_pkg::SUM_W'(gsum_reg[g]);
        end
    end

endmodule

### rtl/perceptron_branch_predictor.sv
// Perceptron branch predictor, top level.
//
// Input words arrive on s_axis: tuser carries the operation (predict or train),
// tdata the entry index, the global history and the outcome. Every input word
// gives one output word on m_axis with the prediction, the dot product before
// any update and a flag that the weights were trained. The user must write
// train_threshold via cfg_wr_en/cfg_wr_data only while idle (not enforced).
//
// One word is in flight at a time. The row is read from the weight memory at
// the accept edge; in the next cycle the 17 lanes feed the registered group
// sums; in ST_FIN the groups are summed, the training decision is taken, the
// row is written back and the result register is loaded. A new word is taken
// only after ST_FIN has finished, bounded by the single row port of the weight
// memory and the two-level adder tree.
//
// Reset clears the per-row valid bits, so every row reads as zero weights
// straight away, and sets the threshold to 45. When m_axis stalls, the result
// holds in its register and the next finished word waits before write-back.
`timescale 1ns / 1ps

module perceptron_branch_predictor
(
    input  logic                            clk,
    input  logic                            rst_n,
    // configuration: train_threshold
    input  logic                            cfg_wr_en,
    input  logic [ppb_pkg::THR_W-1:0]       cfg_wr_data,
    // tdata: entry_index [7:0], history [23:8], taken [24], zero [31:25]
    input  logic [ppb_pkg::IN_DATA_W-1:0]   s_axis_tdata,
    // tuser: operation [0]
    input  logic [ppb_pkg::USER_W-1:0]      s_axis_tuser,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // tdata: prediction [0], dot_sum [13:1], was_trained [14], zero [15]
    output logic [ppb_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SUM  = 2'd1;
    localparam logic [1:0] ST_FIN  = 2'd2;

    localparam int WB   = ppb_pkg::WEIGHT_BITS;
    localparam int CW   = ppb_pkg::CMP_W;
    localparam logic signed [CW-1:0] DOT_HI = CW'(ppb_pkg::DOT_MAX);
    localparam logic signed [CW-1:0] DOT_LO = CW'(-ppb_pkg::DOT_MAX - 1);

    logic [1:0]                      state_reg, state_next;
    logic [ppb_pkg::THR_W-1:0]       thr_reg;

    // captured input word
    logic [ppb_pkg::USER_W-1:0]      op_reg;
    logic [ppb_pkg::IDX_W-1:0]       idx_reg;
    logic [ppb_pkg::HIST_BITS-1:0]   hist_reg;
    logic                            taken_reg;

    // weight memory with one valid bit per row
    logic [ppb_pkg::ROW_W-1:0]       wmem [ppb_pkg::TABLE_ENTRIES];
    logic [ppb_pkg::TABLE_ENTRIES-1:0] row_ok_reg;
    logic [ppb_pkg::ROW_W-1:0]       rd_row_reg;
    logic                            rd_ok_reg;

    // output register
    logic                            out_valid_reg;
    logic [ppb_pkg::OUT_DATA_W-1:0]  out_data_reg;

    logic                            in_acc;
    logic                            fin_go;
    logic [ppb_pkg::IDX_W-1:0]       in_idx;
    logic [ppb_pkg::ROW_LEN-1:0]     sign_bits;
    ppb_pkg::weight_t                lane_w   [ppb_pkg::ROW_LEN];
    ppb_pkg::weight_t                contrib  [ppb_pkg::ROW_LEN];
    ppb_pkg::lane_out_t              lane_out [ppb_pkg::ROW_LEN];
    logic [ppb_pkg::ROW_W-1:0]       new_row;
    ppb_pkg::sum_t                   sum;
    ppb_pkg::sum_t                   sum_abs;
    logic [ppb_pkg::MAG_W-1:0]       mag;
    logic signed [CW-1:0]            sum_wide;
    logic [ppb_pkg::DOT_W-1:0]       dot_sum;
    logic                            prediction;
    logic                            train;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign fin_go        = (state_reg == ST_FIN) && (!out_valid_reg || m_axis_tready);
    assign in_idx        = s_axis_tdata[ppb_pkg::IDX_W-1:0];

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (in_acc) state_next = ST_SUM;
            ST_SUM:  state_next = ST_FIN;
            ST_FIN:  if (fin_go) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // threshold register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg <= ppb_pkg::THR_W'(ppb_pkg::THR_RESET);
        end
        else if (cfg_wr_en)
        begin
            thr_reg <= cfg_wr_data;
        end
    end

    // input word capture
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            op_reg    <= s_axis_tuser;
            idx_reg   <= in_idx;
            hist_reg  <= ppb_pkg::HIST_BITS'(
                             s_axis_tdata[ppb_pkg::IN_IDX_W +: ppb_pkg::IN_HIST_W]);
            taken_reg <= s_axis_tdata[ppb_pkg::IN_IDX_W + ppb_pkg::IN_HIST_W];
        end
    end

    // row read at accept, row write-back when training
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            rd_row_reg <= wmem[in_idx];
        end
        if (fin_go && train)
        begin
            wmem[idx_reg] <= new_row;
        end
    end

    // row valid bits: an unwritten row reads as zero weights
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_ok_reg <= '0;
            rd_ok_reg  <= 1'b0;
        end
        else
        begin
            if (in_acc)
            begin
                rd_ok_reg <= row_ok_reg[in_idx];
            end
            if (fin_go && train)
            begin
                row_ok_reg[idx_reg] <= 1'b1;
            end
        end
    end

    // bias lane always sees a set bit
    assign sign_bits = {hist_reg, 1'b1};

    // weight lanes
    for (genvar k = 0; k < ppb_pkg::ROW_LEN; k++)
    begin : g_lane
        assign lane_w[k] = rd_ok_reg ? rd_row_reg[k * WB +: WB] : '0;

        ppb_lane u_lane
        (
            .weight   (lane_w[k]),
            .hbit     (sign_bits[k]),
            .taken    (taken_reg),
            .lane_out (lane_out[k])
        );

        assign contrib[k]            = lane_out[k].contrib;
        assign new_row[k * WB +: WB] = lane_out[k].upd;
    end

    // merging tree, group sums loaded while the row is fresh
    ppb_merge u_merge
    (
        .clk     (clk),
        .load    (state_reg == ST_SUM),
        .contrib (contrib),
        .sum     (sum)
    );

    // training decision on the full sum
    assign sum_abs    = sum[ppb_pkg::SUM_W-1] ? -sum : sum;
    assign mag        = ppb_pkg::MAG_W'($unsigned(sum_abs));
    assign prediction = !sum[ppb_pkg::SUM_W-1];

    always_comb
    begin
        train = 1'b0;
        if (op_reg == ppb_pkg::OP_TRAIN)
        begin
            train = (sum[ppb_pkg::SUM_W-1] && taken_reg)
                 || (prediction && (sum != '0) && !taken_reg)
                 || (mag <= ppb_pkg::MAG_W'(thr_reg));
        end
    end

    // dot_sum clipped to its field
    assign sum_wide = CW'(sum);

    always_comb
    begin
        if (sum_wide > DOT_HI)
        begin
            dot_sum = ppb_pkg::DOT_W'(DOT_HI);
        end
        else if (sum_wide < DOT_LO)
        begin
            dot_sum = ppb_pkg::DOT_W'(DOT_LO);
        end
        else
        begin
            dot_sum = ppb_pkg::DOT_W'(sum_wide);
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (fin_go)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fin_go)
        begin
            out_data_reg <= ppb_pkg::OUT_DATA_W'({train, dot_sum, prediction});
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

endmodule

### rtl/ppb_checker.sv
// port-level checks of the perceptron branch predictor, bound to the top level
`timescale 1ns / 1ps

module ppb_checker
(
    input logic                            clk,
    input logic                            rst_n,
    input logic                            s_axis_tvalid,
    input logic                            s_axis_tready,
    input logic [ppb_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
    input logic                            m_axis_tvalid,
    input logic                            m_axis_tready
);

    // a stalled result word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result word changed while stalled");

    // one word at a time: no second accept straight after an accept
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input taken while a word is in flight");

    // prediction agrees with the sign of dot_sum
    a_pred_sign: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[0] == !m_axis_tdata[ppb_pkg::DOT_W])
        else $error("prediction disagrees with dot_sum sign");

    // a new result only appears while the input side is closed
    a_new_result: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
        else $error("result appeared without a word in flight");

endmodule

bind perceptron_branch_predictor ppb_checker u_ppb_checker (.*);

### verif/perceptron_branch_predictor_test.sv
// self-checking testbench for the perceptron branch predictor
`timescale 1ns / 1ps

module perceptron_branch_predictor_test;

    localparam int STALL_LIMIT = 1000;
    localparam int PHASE_WORDS = 250;

    // one expected output word
    typedef struct {
        logic                             taken_pred;
        logic signed [ppb_pkg::DOT_W-1:0] dot_sum;
        logic                             trained;
    } verdict_t;

    // perceptron table, threshold and the queue of expected output words
    class perceptron_checker;
        int       weights [ppb_pkg::TABLE_ENTRIES][ppb_pkg::ROW_LEN];
        int       threshold;
        verdict_t pending_verdicts [$];
        int       errors;

        function new();
            threshold = ppb_pkg::THR_RESET;
            errors    = 0;
            foreach (weights[r, k])
                weights[r][k] = 0;
        endfunction

        function int saturate_weight(int v);
            if (v > ppb_pkg::W_MAX)
                return ppb_pkg::W_MAX;
            if (v < -ppb_pkg::W_MAX)
                return -ppb_pkg::W_MAX;
            return v;
        endfunction

        // accepted input word: form the dot product, train the row, queue the verdict
        function void note_branch(logic [ppb_pkg::IN_DATA_W-1:0] data,
                                  logic [ppb_pkg::USER_W-1:0] op);
            logic [ppb_pkg::IN_HIST_W-1:0] hist;
            int       row;
            int       t;
            int       s;
            int       mag;
            int       k;
            bit       trn;
            verdict_t v;
            row  = int'(data[ppb_pkg::IN_IDX_W-1:0]) % ppb_pkg::TABLE_ENTRIES;
            hist = data[ppb_pkg::IN_IDX_W +: ppb_pkg::IN_HIST_W];
            t    = data[ppb_pkg::IN_IDX_W + ppb_pkg::IN_HIST_W] ? 1 : -1;
            s    = weights[row][0];
            for (k = 0; k < ppb_pkg::HIST_BITS; k++)
                s += hist[k] ? weights[row][k+1] : -weights[row][k+1];
            trn = 1'b0;
            if (op == ppb_pkg::OP_TRAIN)
            begin
                mag = (s < 0) ? -s : s;
                trn = (s < 0 && t > 0) || (s > 0 && t < 0) || (mag <= threshold);
            end
            if (trn)
            begin
                weights[row][0] = saturate_weight(weights[row][0] + t);
                for (k = 0; k < ppb_pkg::HIST_BITS; k++)
                    weights[row][k+1] = saturate_weight(weights[row][k+1] + (hist[k] ? t : -t));
            end
            v.taken_pred = (s >= 0);
            v.trained    = trn;
            if (s > ppb_pkg::DOT_MAX)
                v.dot_sum = ppb_pkg::DOT_W'(ppb_pkg::DOT_MAX);
            else if (s < -ppb_pkg::DOT_MAX - 1)
                v.dot_sum = ppb_pkg::DOT_W'(-ppb_pkg::DOT_MAX - 1);
            else
                v.dot_sum = ppb_pkg::DOT_W'(s);
            pending_verdicts.push_back(v);
        endfunction

        function void mismatch(string field, int exp_val, int act_val);
            errors++;
            $display("%0t: %s expected %0d actual %0d", $time, field, exp_val, act_val);
        endfunction

        // accepted output word: compare field by field with the oldest verdict
        function void check_verdict(logic [ppb_pkg::OUT_DATA_W-1:0] data);
            verdict_t v;
            logic signed [ppb_pkg::DOT_W-1:0] got_sum;
            if (pending_verdicts.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected output word expected none actual %h", $time, data);
                return;
            end
            v       = pending_verdicts.pop_front();
            got_sum = data[ppb_pkg::DOT_W:1];
            if (data[0] !== v.taken_pred)
                mismatch("prediction", int'(v.taken_pred), int'(data[0]));
            if (got_sum !== v.dot_sum)
                mismatch("dot_sum", int'(v.dot_sum), int'(got_sum));
            if (data[ppb_pkg::DOT_W+1] !== v.trained)
                mismatch("was_trained", int'(v.trained), int'(data[ppb_pkg::DOT_W+1]));
        endfunction
    endclass

    logic                              clk;
    logic                              rst_n;
    logic                              cfg_wr_en;
    logic [ppb_pkg::THR_W-1:0]         cfg_wr_data;
    logic [ppb_pkg::IN_DATA_W-1:0]     s_axis_tdata;
    logic [ppb_pkg::USER_W-1:0]        s_axis_tuser;
    logic                              s_axis_tvalid;
    logic                              s_axis_tready;
    logic [ppb_pkg::OUT_DATA_W-1:0]    m_axis_tdata;
    logic                              m_axis_tvalid;
    logic                              m_axis_tready;

    perceptron_checker board;
    bit                calm;
    int                quiet_cycles;

    perceptron_branch_predictor i_dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready)
    );

    // 10 ns clock
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // gap length: mostly none or short, now and then long
    function automatic int pick_gap();
        int r;
        if (calm)
            return 0;
        r = int'($urandom_range(0, 99));
        if (r < 55)
            return 0;
        if (r < 90)
            return int'($urandom_range(1, 3));
        return int'($urandom_range(8, 40));
    endfunction

    // handshake monitor: results first, then the newly accepted word
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
                board.check_verdict(m_axis_tdata);
            if (s_axis_tvalid && s_axis_tready)
                board.note_branch(s_axis_tdata, s_axis_tuser);
        end
    end

    // watchdog on cycles without any accepted word
    always @(posedge clk)
    begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("Mismatches found");
                $finish;
            end
        end
    end

    // result side back-pressure
    initial
    begin
        int stall;
        m_axis_tready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            m_axis_tready <= 1'b1;
            repeat ($urandom_range(1, 8)) @(posedge clk);
            stall = pick_gap();
            if (stall > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
        end
    end

    // present one branch word and hold it until it is taken
    task automatic issue_branch(input logic [ppb_pkg::USER_W-1:0] op, input int idx,
                                input int hist, input bit tk);
        logic [ppb_pkg::IN_DATA_W-1:0] word;
        int gap;
        word = '0;
        word[ppb_pkg::IN_IDX_W-1:0]                  = ppb_pkg::IN_IDX_W'(idx);
        word[ppb_pkg::IN_IDX_W +: ppb_pkg::IN_HIST_W] = ppb_pkg::IN_HIST_W'(hist);
        word[ppb_pkg::IN_IDX_W + ppb_pkg::IN_HIST_W]  = tk;
        gap = pick_gap();
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= word;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
    endtask

    // stop sending and wait for every outstanding result
    task automatic wait_drain();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (board.pending_verdicts.size() != 0)
            @(posedge clk);
    endtask

    task automatic set_threshold(input int value);
        wait_drain();
        repeat (4) @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= ppb_pkg::THR_W'(value);
        @(posedge clk);
        board.threshold = value;
        cfg_wr_en <= 1'b0;
    endtask

    // random traffic: training runs on hot rows with learnable outcomes, plus noise
    task automatic run_phase(input int budget, input bit saturate);
        int sent;
        int idx;
        int base;
        int hist;
        int len;
        int pick;
        int n;
        bit tk;
        logic [ppb_pkg::USER_W-1:0] op;
        sent = 0;
        // drive one row all the way into weight saturation
        if (saturate)
        begin
            idx  = int'($urandom_range(0, ppb_pkg::TABLE_ENTRIES - 1));
            base = int'($urandom_range(0, 16'hFFFF));
            tk   = 1'($urandom_range(0, 1));
            repeat (140)
                issue_branch(ppb_pkg::OP_TRAIN, idx, base, tk);
            issue_branch(ppb_pkg::OP_PREDICT, idx, base, !tk);
            issue_branch(ppb_pkg::OP_PREDICT, idx, ~base, tk);
            sent += 142;
        end
        while (sent < budget)
        begin
            calm = ($urandom_range(0, 5) == 0);
            if ($urandom_range(0, 9) < 6)
            begin
                idx  = ($urandom_range(0, 1) != 0)
                     ? int'($urandom_range(0, 7))
                     : int'($urandom_range(0, ppb_pkg::TABLE_ENTRIES - 1));
                base = int'($urandom_range(0, 16'hFFFF));
                pick = int'($urandom_range(0, ppb_pkg::IN_HIST_W - 1));
                len  = int'($urandom_range(10, 40));
                for (n = 0; n < len; n++)
                begin
                    hist = base;
                    if ($urandom_range(0, 3) == 0)
                        hist = hist ^ (1 << $urandom_range(0, ppb_pkg::IN_HIST_W - 1));
                    tk = hist[pick] ^ ($urandom_range(0, 9) == 0);
                    op = ($urandom_range(0, 4) == 0) ? ppb_pkg::OP_PREDICT : ppb_pkg::OP_TRAIN;
                    issue_branch(op, idx, hist, tk);
                end
                sent += len;
            end
            else
            begin
                op = ($urandom_range(0, 1) != 0) ? ppb_pkg::OP_TRAIN : ppb_pkg::OP_PREDICT;
                issue_branch(op, int'($urandom_range(0, ppb_pkg::TABLE_ENTRIES - 1)),
                             int'($urandom_range(0, 16'hFFFF)), 1'($urandom_range(0, 1)));
                sent++;
            end
            // sender holds off until the block has drained
            if ($urandom_range(0, 29) == 0)
                wait_drain();
        end
        calm = 1'b0;
    endtask

    initial
    begin
        board = new();
        calm  = 1'b0;
        quiet_cycles  = 0;
        rst_n         <= 1'b0;
        cfg_wr_en     <= 1'b0;
        cfg_wr_data   <= '0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= ppb_pkg::OP_PREDICT;
        s_axis_tvalid <= 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: cleared table, both operations, extreme rows and histories
        issue_branch(ppb_pkg::OP_PREDICT, 0, 16'h0000, 1'b1);
        issue_branch(ppb_pkg::OP_TRAIN, 0, 16'h0000, 1'b0);
        issue_branch(ppb_pkg::OP_PREDICT, 0, 16'h0000, 1'b0);
        issue_branch(ppb_pkg::OP_PREDICT, 0, 16'hFFFF, 1'b1);
        issue_branch(ppb_pkg::OP_TRAIN, 0, 16'hFFFF, 1'b1);
        issue_branch(ppb_pkg::OP_TRAIN, 255, 16'hFFFF, 1'b1);
        issue_branch(ppb_pkg::OP_TRAIN, 255, 16'hFFFF, 1'b1);
        issue_branch(ppb_pkg::OP_TRAIN, 255, 16'hFFFF, 1'b1);
        issue_branch(ppb_pkg::OP_PREDICT, 255, 16'h0000, 1'b1);
        issue_branch(ppb_pkg::OP_TRAIN, 128, 16'hA5A5, 1'b0);
        issue_branch(ppb_pkg::OP_TRAIN, 128, 16'h5A5A, 1'b1);
        issue_branch(ppb_pkg::OP_PREDICT, 128, 16'hA5A5, 1'b0);
        issue_branch(ppb_pkg::OP_TRAIN, 1, 16'h8001, 1'b1);
        issue_branch(ppb_pkg::OP_PREDICT, 1, 16'h7FFE, 1'b1);

        // zero threshold: a zero sum still trains, an agreeing sum does not
        set_threshold(0);
        issue_branch(ppb_pkg::OP_TRAIN, 2, 16'h0000, 1'b1);
        issue_branch(ppb_pkg::OP_TRAIN, 2, 16'h0000, 1'b1);
        issue_branch(ppb_pkg::OP_TRAIN, 2, 16'h0000, 1'b0);
        issue_branch(ppb_pkg::OP_TRAIN, 2, 16'h0000, 1'b0);
        issue_branch(ppb_pkg::OP_PREDICT, 2, 16'h0000, 1'b0);
        issue_branch(ppb_pkg::OP_TRAIN, 2, 16'hFFFF, 1'b0);

        // random phases over several thresholds
        set_threshold(ppb_pkg::THR_RESET);
        run_phase(PHASE_WORDS, 1'b0);
        set_threshold(0);
        run_phase(PHASE_WORDS, 1'b0);
        set_threshold(2 ** ppb_pkg::THR_W - 1);
        run_phase(PHASE_WORDS, 1'b1);
        set_threshold(int'($urandom_range(1, 2158)));
        run_phase(PHASE_WORDS, 1'b0);
        set_threshold(2159);
        run_phase(PHASE_WORDS, 1'b1);
        set_threshold(1);
        run_phase(PHASE_WORDS, 1'b0);
        set_threshold(int'($urandom_range(0, 2 ** ppb_pkg::THR_W - 1)));
        run_phase(PHASE_WORDS, 1'b0);

        // final drain and settle
        wait_drain();
        repeat (8) @(posedge clk);
        if (board.errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
